// File: hw/rtl/cpp_pkg.sv
// Shared types and constants for the command packet parser.
// No dependencies; imported by every module of the block.
package cpp_pkg;

    localparam int unsigned BYTE_W  = 8;
    localparam int unsigned SERVO_W = 16;
    localparam int unsigned STORE_DEPTH = 8;
    localparam int unsigned IDX_W = $clog2(STORE_DEPTH);

    localparam logic [BYTE_W-1:0] CMD_TONE  = 8'h11;
    localparam logic [BYTE_W-1:0] CMD_MOTOR = 8'h12;
    localparam logic [BYTE_W-1:0] CMD_SERVO = 8'h15;
    localparam logic [BYTE_W-1:0] SIZE_VARIABLE = 8'hFF;
    localparam logic [BYTE_W-1:0] MOTOR_RESET = 8'h80;

    // payload size by low three bits of the command byte
    localparam logic [BYTE_W-1:0] SIZE_TABLE [8] = '{
        8'd0, 8'd1, 8'd2, 8'd4, 8'd6, 8'd8, 8'd12, 8'd255
    };

    typedef enum logic [1:0] {
        PH_COMMAND = 2'd0,
        PH_LENGTH  = 2'd1,
        PH_PAYLOAD = 2'd2,
        PH_DISCARD = 2'd3
    } cpp_phase_t;

    typedef enum logic [2:0] {
        EV_BEEP    = 3'd0,
        EV_MOTOR   = 3'd1,
        EV_SERVO   = 3'd2,
        EV_MISSING = 3'd3,
        EV_UNKNOWN = 3'd4
    } cpp_event_t;

    typedef struct packed {
        logic [BYTE_W-1:0] data_byte;
        logic              last_of_packet;
    } cpp_beat_t;

    typedef struct packed {
        cpp_event_t         event_res;
        logic               beep_on;
        logic [BYTE_W-1:0]  beep_ms;
        logic [BYTE_W-1:0]  motor_a;
        logic [BYTE_W-1:0]  motor_b;
        logic [SERVO_W-1:0] servo_0;
        logic [SERVO_W-1:0] servo_1;
        logic [SERVO_W-1:0] servo_2;
        logic [SERVO_W-1:0] servo_3;
        logic [BYTE_W-1:0]  error_detail;
    } cpp_result_t;

endpackage

// File: hw/rtl/command_packet_parser_top.sv
// Command packet parser: takes host packet bytes one beat at a time, with a flag on the
// final byte, and reports beep, motor, servo, missing-data and unknown-command events.
// A beat is accepted every cycle when the result side keeps up; a beat that yields an
// event passes through one parse step from the input register to the result register;
// a full result slot stalls it. Motor and servo fields always carry current values.
// Depends on cpp_pkg, cpp_in_stage, cpp_parse, cpp_out_stage.
module command_packet_parser_top
    import cpp_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  logic [BYTE_W-1:0]   s_data_byte,
    input  logic                s_last_of_packet,
    output logic                m_valid,
    input  logic                m_ready,
    output logic [2:0]          m_event_res,
    output logic                m_beep_on,
    output logic [BYTE_W-1:0]   m_beep_ms,
    output logic [BYTE_W-1:0]   m_motor_a,
    output logic [BYTE_W-1:0]   m_motor_b,
    output logic [SERVO_W-1:0]  m_servo_0,
    output logic [SERVO_W-1:0]  m_servo_1,
    output logic [SERVO_W-1:0]  m_servo_2,
    output logic [SERVO_W-1:0]  m_servo_3,
    output logic [BYTE_W-1:0]   m_error_detail
);

    cpp_beat_t   s_beat;
    cpp_beat_t   beat;
    logic        beat_valid;
    logic        slot_free;
    logic        step;
    logic        emit;
    cpp_result_t res;
    cpp_result_t m_res;

    assign s_beat.data_byte      = s_data_byte;
    assign s_beat.last_of_packet = s_last_of_packet;
    assign step = beat_valid && slot_free;

    cpp_in_stage u_in (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_beat     (s_beat),
        .take       (step),
        .beat_valid (beat_valid),
        .beat       (beat)
    );

    cpp_parse u_parse (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step    (step),
        .beat    (beat),
        .emit    (emit),
        .res     (res)
    );

    cpp_out_stage u_out (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .load       (step),
        .load_valid (emit),
        .load_res   (res),
        .slot_free  (slot_free),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_res      (m_res)
    );

    assign m_event_res    = m_res.event_res;
    assign m_beep_on      = m_res.beep_on;
    assign m_beep_ms      = m_res.beep_ms;
    assign m_motor_a      = m_res.motor_a;
    assign m_motor_b      = m_res.motor_b;
    assign m_servo_0      = m_res.servo_0;
    assign m_servo_1      = m_res.servo_1;
    assign m_servo_2      = m_res.servo_2;
    assign m_servo_3      = m_res.servo_3;
    assign m_error_detail = m_res.error_detail;

endmodule

// File: hw/rtl/cpp_in_stage.sv
// Input register for packet bytes.
// Depends on cpp_pkg (cpp_beat_t).
module cpp_in_stage
    import cpp_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    input  cpp_beat_t s_beat,
    input  logic      take,
    output logic      beat_valid,
    output cpp_beat_t beat
);

    logic      valid_reg;
    logic      valid_next;
    cpp_beat_t beat_reg;
    logic      load;

    assign s_ready = !valid_reg || take;
    assign load    = s_valid && s_ready;

    always_comb begin
        if (load) begin
            valid_next = 1'b1;
        end else if (take) begin
            valid_next = 1'b0;
        end else begin
            valid_next = valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            beat_reg <= s_beat;
        end
    end

    assign beat_valid = valid_reg;
    assign beat       = beat_reg;

endmodule

// File: hw/rtl/cpp_parse.sv
// Parser state and per-byte decode: phase, payload store, motor and servo values.
// Depends on cpp_pkg (size table, codes, result type).
module cpp_parse
    import cpp_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        step,
    input  cpp_beat_t   beat,
    output logic        emit,
    output cpp_result_t res
);

    cpp_phase_t         phase_reg, phase_next;
    logic [BYTE_W-1:0]  cmd_reg, cmd_next;
    logic [BYTE_W-1:0]  rem_reg, rem_next;
    logic [IDX_W-1:0]   idx_reg, idx_next;
    logic [BYTE_W-1:0]  size_reg, size_next;
    logic [BYTE_W-1:0]  store_reg [STORE_DEPTH];
    logic [BYTE_W-1:0]  store_next [STORE_DEPTH];
    logic [BYTE_W-1:0]  motor_reg [2];
    logic [BYTE_W-1:0]  motor_next [2];
    logic [SERVO_W-1:0] servo_reg [4];
    logic [SERVO_W-1:0] servo_next [4];

    logic               do_start;
    logic [BYTE_W-1:0]  start_size;
    logic               do_finish;
    logic [BYTE_W-1:0]  table_size;
    logic [BYTE_W-1:0]  b;
    logic               last;
    cpp_event_t         ev;
    logic               on;
    logic [BYTE_W-1:0]  ms;
    logic [BYTE_W-1:0]  detail;

    assign b          = beat.data_byte;
    assign last       = beat.last_of_packet;
    assign table_size = SIZE_TABLE[b[2:0]];

    always_comb begin
        phase_next = phase_reg;
        cmd_next   = cmd_reg;
        rem_next   = rem_reg;
        idx_next   = idx_reg;
        size_next  = size_reg;
        store_next = store_reg;
        motor_next = motor_reg;
        servo_next = servo_reg;
        do_start   = 1'b0;
        start_size = '0;
        do_finish  = 1'b0;
        emit       = 1'b0;
        ev         = EV_BEEP;
        on         = 1'b0;
        ms         = '0;
        detail     = '0;

        unique case (phase_reg)
            PH_COMMAND: begin
                cmd_next = b;
                if (table_size == SIZE_VARIABLE) begin
                    if (last) begin
                        emit       = 1'b1;
                        ev         = EV_MISSING;
                        detail     = SIZE_VARIABLE;
                        phase_next = PH_COMMAND;
                    end else begin
                        phase_next = PH_LENGTH;
                    end
                end else begin
                    do_start   = 1'b1;
                    start_size = table_size;
                end
            end
            PH_LENGTH: begin
                do_start   = 1'b1;
                start_size = b;
            end
            PH_PAYLOAD: begin
                store_next[idx_reg] = b;
                idx_next = idx_reg + IDX_W'(1);
                rem_next = rem_reg - 8'd1;
                if (rem_next == '0) begin
                    do_finish = 1'b1;
                end else if (last) begin
                    emit       = 1'b1;
                    ev         = EV_MISSING;
                    detail     = size_reg;
                    phase_next = PH_COMMAND;
                end
            end
            PH_DISCARD: begin
                if (last) begin
                    phase_next = PH_COMMAND;
                end
            end
        endcase

        if (do_start) begin
            size_next = start_size;
            rem_next  = start_size;
            idx_next  = '0;
            if (start_size == '0) begin
                do_finish = 1'b1;
            end else if (last) begin
                emit       = 1'b1;
                ev         = EV_MISSING;
                detail     = start_size;
                phase_next = PH_COMMAND;
            end else begin
                phase_next = PH_PAYLOAD;
            end
        end

        if (do_finish) begin
            emit       = 1'b1;
            phase_next = PH_COMMAND;
            case (cmd_next)
                CMD_TONE: begin
                    ev = EV_BEEP;
                    on = (store_next[0] != '0);
                    ms = store_next[0];
                end
                CMD_MOTOR: begin
                    ev = EV_MOTOR;
                    motor_next[0] = store_next[0];
                    motor_next[1] = store_next[1];
                end
                CMD_SERVO: begin
                    ev = EV_SERVO;
                    servo_next[0] = {store_next[1], store_next[0]};
                    servo_next[1] = {store_next[3], store_next[2]};
                    servo_next[2] = {store_next[5], store_next[4]};
                    servo_next[3] = {store_next[7], store_next[6]};
                end
                default: begin
                    ev         = EV_UNKNOWN;
                    detail     = cmd_next;
                    phase_next = last ? PH_COMMAND : PH_DISCARD;
                end
            endcase
        end
    end

    always_comb begin
        res.event_res    = ev;
        res.beep_on      = on;
        res.beep_ms      = ms;
        res.motor_a      = motor_next[0];
        res.motor_b      = motor_next[1];
        res.servo_0      = servo_next[0];
        res.servo_1      = servo_next[1];
        res.servo_2      = servo_next[2];
        res.servo_3      = servo_next[3];
        res.error_detail = detail;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_COMMAND;
            cmd_reg   <= '0;
            rem_reg   <= '0;
            idx_reg   <= '0;
            size_reg  <= '0;
            motor_reg <= '{MOTOR_RESET, MOTOR_RESET};
            servo_reg <= '{default: '0};
        end else if (step) begin
            phase_reg <= phase_next;
            cmd_reg   <= cmd_next;
            rem_reg   <= rem_next;
            idx_reg   <= idx_next;
            size_reg  <= size_next;
            motor_reg <= motor_next;
            servo_reg <= servo_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (step) begin
            store_reg <= store_next;
        end
    end

    a_discard_ends: assert property (@(posedge aclk) disable iff (!aresetn)
        step && phase_reg == PH_DISCARD && last |=> phase_reg == PH_COMMAND)
        else $error("discard phase did not end on last beat");

    a_missing_on_last: assert property (@(posedge aclk) disable iff (!aresetn)
        step && emit && res.event_res == EV_MISSING |-> last)
        else $error("missing data reported before end of packet");

    a_length_leaves: assert property (@(posedge aclk) disable iff (!aresetn)
        step && phase_reg == PH_LENGTH |=> phase_reg != PH_LENGTH)
        else $error("length phase held over a beat");

    a_unknown_detail: assert property (@(posedge aclk) disable iff (!aresetn)
        step && emit && res.event_res == EV_UNKNOWN |-> res.error_detail == cmd_next)
        else $error("unknown command detail does not match command");

endmodule

// File: hw/rtl/cpp_out_stage.sv
// Result register for parser events.
// Depends on cpp_pkg (cpp_result_t).
module cpp_out_stage
    import cpp_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        load,
    input  logic        load_valid,
    input  cpp_result_t load_res,
    output logic        slot_free,
    output logic        m_valid,
    input  logic        m_ready,
    output cpp_result_t m_res
);

    logic        valid_reg;
    logic        valid_next;
    cpp_result_t res_reg;

    assign slot_free = !valid_reg || m_ready;

    always_comb begin
        if (load) begin
            valid_next = load_valid;
        end else if (m_ready) begin
            valid_next = 1'b0;
        end else begin
            valid_next = valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load && load_valid) begin
            res_reg <= load_res;
        end
    end

    assign m_valid = valid_reg;
    assign m_res   = res_reg;

endmodule

// File: test/command_packet_parser_top_test.sv
// Testbench for command_packet_parser_top: drives packet bytes, tracks a parser model of
// its own and compares every event beat field by field. Needs cpp_pkg and the parser RTL.
`timescale 1ns / 100ps

module command_packet_parser_top_test;
    import cpp_pkg::*;

    localparam logic [2:0] VAR_SEL = 3'd7;
    localparam int RANDOM_BEATS = 1900;
    localparam int CALM_BEATS = 400;
    localparam int STALL_CYCLES = 300;

    logic                aclk = 1'b0;
    logic                aresetn = 1'b0;
    logic                s_valid = 1'b0;
    logic                s_ready;
    logic [BYTE_W-1:0]   s_data_byte = '0;
    logic                s_last_of_packet = 1'b0;
    logic                m_valid;
    logic                m_ready = 1'b0;
    logic [2:0]          m_event_res;
    logic                m_beep_on;
    logic [BYTE_W-1:0]   m_beep_ms;
    logic [BYTE_W-1:0]   m_motor_a;
    logic [BYTE_W-1:0]   m_motor_b;
    logic [SERVO_W-1:0]  m_servo_0;
    logic [SERVO_W-1:0]  m_servo_1;
    logic [SERVO_W-1:0]  m_servo_2;
    logic [SERVO_W-1:0]  m_servo_3;
    logic [BYTE_W-1:0]   m_error_detail;

    command_packet_parser_top dut (.*);

    // parser model state
    cpp_phase_t          parse_phase = PH_COMMAND;
    logic [BYTE_W-1:0]   parse_cmd = '0;
    logic [BYTE_W-1:0]   parse_left = '0;
    logic [IDX_W-1:0]    parse_idx = '0;
    logic [BYTE_W-1:0]   parse_size = '0;
    logic [BYTE_W-1:0]   parse_store [STORE_DEPTH];
    logic [BYTE_W-1:0]   motor_pwr [2] = '{MOTOR_RESET, MOTOR_RESET};
    logic [SERVO_W-1:0]  servo_pw [4] = '{16'd0, 16'd0, 16'd0, 16'd0};

    cpp_result_t         event_q [$];
    logic [BYTE_W-1:0]   pkt_q [$];

    int  errors = 0;
    int  beats_sent = 0;
    bit  idle_en = 1'b0;
    int  stall_req = 0;
    int  stall_seen = 0;
    int  hold_cnt = 0;

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    initial begin
        #2ms;
        $display("TEST FAILED");
        $finish;
    end

    function automatic cpp_result_t make_event(cpp_event_t ev, logic on, logic [7:0] ms,
                                               logic [7:0] detail);
        cpp_result_t r;
        r.event_res    = ev;
        r.beep_on      = on;
        r.beep_ms      = ms;
        r.motor_a      = motor_pwr[0];
        r.motor_b      = motor_pwr[1];
        r.servo_0      = servo_pw[0];
        r.servo_1      = servo_pw[1];
        r.servo_2      = servo_pw[2];
        r.servo_3      = servo_pw[3];
        r.error_detail = detail;
        return r;
    endfunction

    task automatic finish_cmd(input logic is_last);
        parse_phase = PH_COMMAND;
        case (parse_cmd)
            CMD_TONE: begin
                event_q.push_back(make_event(EV_BEEP, parse_store[0] != 8'd0,
                                             parse_store[0], 8'd0));
            end
            CMD_MOTOR: begin
                motor_pwr[0] = parse_store[0];
                motor_pwr[1] = parse_store[1];
                event_q.push_back(make_event(EV_MOTOR, 1'b0, 8'd0, 8'd0));
            end
            CMD_SERVO: begin
                for (int i = 0; i < 4; i++)
                    servo_pw[i] = {parse_store[2*i+1], parse_store[2*i]};
                event_q.push_back(make_event(EV_SERVO, 1'b0, 8'd0, 8'd0));
            end
            default: begin
                parse_phase = is_last ? PH_COMMAND : PH_DISCARD;
                event_q.push_back(make_event(EV_UNKNOWN, 1'b0, 8'd0, parse_cmd));
            end
        endcase
    endtask

    task automatic start_payload(input logic [7:0] size, input logic is_last);
        parse_size = size;
        parse_left = size;
        parse_idx  = '0;
        if (size == 8'd0) begin
            finish_cmd(is_last);
        end else if (is_last) begin
            parse_phase = PH_COMMAND;
            event_q.push_back(make_event(EV_MISSING, 1'b0, 8'd0, size));
        end else begin
            parse_phase = PH_PAYLOAD;
        end
    endtask

    task automatic parse_beat(input logic [7:0] b, input logic is_last);
        logic [7:0] sz;
        case (parse_phase)
            PH_COMMAND: begin
                parse_cmd = b;
                sz = SIZE_TABLE[b[2:0]];
                if (sz == SIZE_VARIABLE) begin
                    parse_phase = PH_COMMAND;
                    if (is_last)
                        event_q.push_back(make_event(EV_MISSING, 1'b0, 8'd0, SIZE_VARIABLE));
                    else
                        parse_phase = PH_LENGTH;
                end else begin
                    start_payload(sz, is_last);
                end
            end
            PH_LENGTH: start_payload(b, is_last);
            PH_PAYLOAD: begin
                parse_store[parse_idx] = b;
                parse_idx  = parse_idx + 1'b1;
                parse_left = parse_left - 8'd1;
                if (parse_left == 8'd0) begin
                    finish_cmd(is_last);
                end else if (is_last) begin
                    parse_phase = PH_COMMAND;
                    event_q.push_back(make_event(EV_MISSING, 1'b0, 8'd0, parse_size));
                end
            end
            default: if (is_last) parse_phase = PH_COMMAND;
        endcase
    endtask

    task automatic check_field(input string name, input logic [15:0] want,
                               input logic [15:0] got);
        if (got !== want) begin
            $display("%0t: %s expected %0h, got %0h", $time, name, want, got);
            errors++;
        end
    endtask

    task automatic check_event();
        cpp_result_t e;
        if (event_q.size() == 0) begin
            $display("%0t: event expected none, got event %0d detail %0h",
                     $time, m_event_res, m_error_detail);
            errors++;
        end else begin
            e = event_q.pop_front();
            check_field("event_res", 16'(e.event_res), 16'(m_event_res));
            check_field("beep_on", 16'(e.beep_on), 16'(m_beep_on));
            check_field("beep_ms", 16'(e.beep_ms), 16'(m_beep_ms));
            check_field("motor_a", 16'(e.motor_a), 16'(m_motor_a));
            check_field("motor_b", 16'(e.motor_b), 16'(m_motor_b));
            check_field("servo_0", e.servo_0, m_servo_0);
            check_field("servo_1", e.servo_1, m_servo_1);
            check_field("servo_2", e.servo_2, m_servo_2);
            check_field("servo_3", e.servo_3, m_servo_3);
            check_field("error_detail", 16'(e.error_detail), 16'(m_error_detail));
        end
    endtask

    // input monitor, output checker and result-side ready
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (s_valid && s_ready)
                parse_beat(s_data_byte, s_last_of_packet);
            if (m_valid && m_ready)
                check_event();
            if (stall_req != stall_seen) begin
                stall_seen <= stall_req;
                hold_cnt   <= STALL_CYCLES;
                m_ready    <= 1'b0;
            end else if (hold_cnt > 0) begin
                hold_cnt <= hold_cnt - 1;
                m_ready  <= 1'b0;
            end else begin
                m_ready <= !idle_en || ($urandom_range(99) >= 14);
            end
        end
    end

    task automatic send_beat(input logic [7:0] d, input logic is_last);
        if (idle_en) begin
            while ($urandom_range(99) < 14) begin
                s_valid <= 1'b0;
                @(posedge aclk);
            end
        end
        s_valid          <= 1'b1;
        s_data_byte      <= d;
        s_last_of_packet <= is_last;
        do @(posedge aclk); while (!s_ready);
        beats_sent++;
    endtask

    task automatic send_packet();
        for (int i = 0; i < pkt_q.size(); i++)
            send_beat(pkt_q[i], i == pkt_q.size() - 1);
        pkt_q.delete();
    endtask

    function automatic logic [7:0] rand_byte();
        int r;
        r = $urandom_range(7);
        if (r == 0) return 8'h00;
        if (r == 1) return 8'hFF;
        return 8'($urandom_range(255));
    endfunction

    task automatic push_command(input logic [7:0] code);
        int len;
        pkt_q.push_back(code);
        if (code[2:0] == VAR_SEL) begin
            len = ($urandom_range(49) == 0) ? 255 : $urandom_range(20);
            pkt_q.push_back(8'(len));
        end else begin
            len = SIZE_TABLE[code[2:0]];
        end
        for (int i = 0; i < len; i++)
            pkt_q.push_back(rand_byte());
    endtask

    function automatic logic [7:0] pick_code();
        logic [7:0] c;
        case ($urandom_range(8))
            0, 1: return CMD_TONE;
            2, 3: return CMD_MOTOR;
            4, 5: return CMD_SERVO;
            6, 7: begin
                do c = 8'($urandom_range(255));
                while (c[2:0] == VAR_SEL || c == CMD_TONE || c == CMD_MOTOR || c == CMD_SERVO);
                return c;
            end
            default: begin
                c = 8'($urandom_range(255));
                c[2:0] = VAR_SEL;
                return c;
            end
        endcase
    endfunction

    task automatic test_known_commands();
        // beep on at max, beep off, motor extremes; only the last command of each packet completes on its last beat
        pkt_q = '{CMD_TONE, 8'hFF, CMD_TONE, 8'h00, CMD_MOTOR, 8'h00, 8'hFF};
        send_packet();
        pkt_q = '{CMD_SERVO, 8'hFF, 8'hFF, 8'h00, 8'h00, 8'hFF, 8'h00, 8'h00, 8'hFF};
        send_packet();
    endtask

    task automatic test_special_cases();
        pkt_q = '{8'h07};                       // length byte missing
        send_packet();
        pkt_q = '{8'h00, 8'hAA};                // zero size, then discard
        send_packet();
        pkt_q = '{8'h0F, 8'h00};                // zero length given, error on last beat
        send_packet();
        pkt_q = '{CMD_MOTOR, 8'h34};            // packet ends inside payload
        send_packet();
        pkt_q = '{8'h03, 8'h01, 8'h02, 8'h03, 8'h04};
        send_packet();
    endtask

    task automatic test_backpressure();
        stall_req <= stall_req + 1;
        for (int i = 0; i < 20; i++)
            push_command(CMD_MOTOR);
        send_packet();
    endtask

    task automatic test_random_packets();
        int start;
        int n;
        int keep;
        start = beats_sent;
        while (beats_sent - start < RANDOM_BEATS) begin
            if (beats_sent - start > CALM_BEATS)
                idle_en <= 1'b1;
            if ($urandom_range(99) < 10) begin
                n = $urandom_range(1, 6);
                for (int i = 0; i < n; i++)
                    pkt_q.push_back(8'($urandom_range(255)));
            end else begin
                n = $urandom_range(1, 3);
                for (int i = 0; i < n; i++)
                    push_command(pick_code());
                if ($urandom_range(99) < 15) begin
                    keep = $urandom_range(1, pkt_q.size());
                    while (pkt_q.size() > keep)
                        void'(pkt_q.pop_back());
                end
            end
            send_packet();
        end
    endtask

    initial begin
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_known_commands();
        test_special_cases();
        test_backpressure();
        test_random_packets();
        s_valid <= 1'b0;
        idle_en <= 1'b0;
        while (event_q.size() != 0)
            @(posedge aclk);
        repeat (8) @(posedge aclk);
        if (errors == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
